/* src/wanf_pkg.sv */
// shared constants and types for the weekly alarm next finder
package wanf_pkg;

    localparam int ALARM_COUNT_DEF  = 4;
    localparam int DAYS_PER_WEEK    = 7;
    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int MINUTES_PER_DAY  = HOURS_PER_DAY * MINUTES_PER_HOUR;

    localparam int MINUTE_W    = 14;
    localparam int DIFF_W      = 16;
    localparam int DAY_W       = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 19;
    localparam int WINDOW_W    = 8;
    localparam int OUT_ALARM_W = 2;

    localparam logic [MINUTE_W-1:0] WEEK_MINUTES = MINUTE_W'(DAYS_PER_WEEK * MINUTES_PER_DAY);
    localparam logic [DIFF_W-1:0]   NO_DIFF      = 16'hffff;
    localparam logic [4:0]          HOUR_MAX     = 5'(HOURS_PER_DAY - 1);
    localparam logic [5:0]          MINUTE_MAX   = 6'(MINUTES_PER_HOUR - 1);
    localparam logic [MINUTE_W-1:0] RING_LEAD    = 14'd1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_LAST  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_WINDOW = 3'd4;
    localparam logic [WINDOW_W-1:0]    SKIP_WINDOW_RESET = 8'd8;

    localparam logic OP_TIME = 1'b0;
    localparam logic OP_SKIP = 1'b1;

    typedef struct packed {
        logic       enable;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] days;
    } alarm_t;

    typedef struct packed {
        logic                found;
        logic [DAY_W-1:0]    day;
        logic [4:0]          hour;
        logic [5:0]          minute;
        logic [MINUTE_W-1:0] minutes_until;
    } eval_res_t;

endpackage

/* src/wanf_eval.sv */
// nearest alarm search: per-candidate distance and a min tree
module wanf_eval #(
    parameter int ALARM_COUNT = wanf_pkg::ALARM_COUNT_DEF,
    localparam int ALARM_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1
) (
    input  wanf_pkg::alarm_t                    alarms [ALARM_COUNT],
    input  logic [wanf_pkg::DAY_W-1:0]          skip_days [ALARM_COUNT],
    input  logic [wanf_pkg::MINUTE_W-1:0]       week_minute,
    output logic [ALARM_W-1:0]                  best_alarm,
    output wanf_pkg::eval_res_t                 res
);

    localparam int NCAND = ALARM_COUNT * wanf_pkg::DAYS_PER_WEEK;
    localparam int LV    = $clog2(NCAND);
    localparam int P     = 1 << LV;
    localparam int NODES = 2 * P - 1;

    logic [4:0]                    hour_sat [ALARM_COUNT];
    logic [5:0]                    minute_sat [ALARM_COUNT];
    logic [wanf_pkg::MINUTE_W-1:0] tod [ALARM_COUNT];

    logic [wanf_pkg::DIFF_W-1:0]   node_diff [NODES];
    logic [ALARM_W-1:0]            node_alarm [NODES];
    logic [wanf_pkg::DAY_W-1:0]    node_day [NODES];

    genvar ga, gk, gn;

    generate
        for (ga = 0; ga < ALARM_COUNT; ga++) begin : g_alarm
            assign hour_sat[ga]   = (alarms[ga].hour > wanf_pkg::HOUR_MAX) ?
                                    wanf_pkg::HOUR_MAX : alarms[ga].hour;
            assign minute_sat[ga] = (alarms[ga].minute > wanf_pkg::MINUTE_MAX) ?
                                    wanf_pkg::MINUTE_MAX : alarms[ga].minute;
            assign tod[ga] = wanf_pkg::MINUTE_W'(hour_sat[ga])
                           * wanf_pkg::MINUTE_W'(wanf_pkg::MINUTES_PER_HOUR)
                           + wanf_pkg::MINUTE_W'(minute_sat[ga]);
        end

        for (gk = 0; gk < P; gk++) begin : g_leaf
            if (gk < NCAND) begin : g_real
                localparam int A = gk / wanf_pkg::DAYS_PER_WEEK;
                localparam int D = gk % wanf_pkg::DAYS_PER_WEEK;
                localparam logic [wanf_pkg::MINUTE_W-1:0] DAY_BASE =
                    wanf_pkg::MINUTE_W'(D * wanf_pkg::MINUTES_PER_DAY);
                localparam logic [wanf_pkg::DAY_W-1:0] SKIP_CODE = wanf_pkg::DAY_W'(D + 1);
                logic [wanf_pkg::MINUTE_W-1:0] abs_t;
                logic [wanf_pkg::MINUTE_W-1:0] diff;
                logic                          live;
                assign abs_t = DAY_BASE + tod[A];
                assign diff  = (week_minute <= abs_t) ? (abs_t - week_minute) :
                               (abs_t + wanf_pkg::WEEK_MINUTES - week_minute);
                assign live  = alarms[A].enable && alarms[A].days[D] &&
                               (skip_days[A] != SKIP_CODE);
                assign node_diff[P-1+gk]  = live ? wanf_pkg::DIFF_W'(diff) : wanf_pkg::NO_DIFF;
                assign node_alarm[P-1+gk] = ALARM_W'(A);
                assign node_day[P-1+gk]   = wanf_pkg::DAY_W'(D);
            end else begin : g_pad
                assign node_diff[P-1+gk]  = wanf_pkg::NO_DIFF;
                assign node_alarm[P-1+gk] = '0;
                assign node_day[P-1+gk]   = '0;
            end
        end

        // left child holds the lower candidate, so it wins ties
        for (gn = 0; gn < P - 1; gn++) begin : g_node
            logic take_left;
            assign take_left = node_diff[2*gn+1] <= node_diff[2*gn+2];
            assign node_diff[gn]  = take_left ? node_diff[2*gn+1]  : node_diff[2*gn+2];
            assign node_alarm[gn] = take_left ? node_alarm[2*gn+1] : node_alarm[2*gn+2];
            assign node_day[gn]   = take_left ? node_day[2*gn+1]   : node_day[2*gn+2];
        end
    endgenerate

    logic found;

    assign found      = node_diff[0] != wanf_pkg::NO_DIFF;
    assign best_alarm = node_alarm[0];

    always_comb begin
        res = '0;
        if (found) begin
            res.found         = 1'b1;
            res.day           = node_day[0];
            res.hour          = hour_sat[node_alarm[0]];
            res.minute        = minute_sat[node_alarm[0]];
            res.minutes_until = node_diff[0][wanf_pkg::MINUTE_W-1:0];
        end
    end

endmodule

/* src/weekly_alarm_next_finder.sv */
// weekly alarm next finder top level
// requests pass through the input register, then the result register once it is free
// throughput: one request per cycle while m_ready holds, set by the single evaluation stage
// s_ready follows m_ready combinationally while both the input and result registers are full
// reset clears the alarms, skip marks, week minute, nearest alarm and ring latch
// skip window resets to eight hours
module weekly_alarm_next_finder #(
    parameter int ALARM_COUNT = wanf_pkg::ALARM_COUNT_DEF,
    localparam int ALARM_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wanf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wanf_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic [wanf_pkg::MINUTE_W-1:0]      s_week_minute,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [wanf_pkg::OUT_ALARM_W-1:0]   m_next_alarm,
    output logic [wanf_pkg::DAY_W-1:0]         m_next_weekday,
    output logic [4:0]                         m_next_hour,
    output logic [5:0]                         m_next_minute,
    output logic [wanf_pkg::MINUTE_W-1:0]      m_minutes_until,
    output logic                               m_skip_possible,
    output logic                               m_alarm_active,
    output logic [wanf_pkg::OUT_ALARM_W-1:0]   m_active_alarm
);

    wanf_pkg::alarm_t                alarm_reg [ALARM_COUNT];
    logic [wanf_pkg::DAY_W-1:0]      skip_reg [ALARM_COUNT];
    logic [wanf_pkg::WINDOW_W-1:0]   window_reg;
    logic [wanf_pkg::MINUTE_W-1:0]   cwm_reg;
    logic                            nearest_valid_reg;
    logic [ALARM_W-1:0]              nearest_alarm_reg;
    logic [wanf_pkg::DAY_W-1:0]      nearest_day_reg;
    logic                            ring_latch_reg;
    logic [ALARM_W-1:0]              ringing_reg;

    logic                            in_valid_reg;
    logic                            in_opcode_reg;
    logic [wanf_pkg::MINUTE_W-1:0]   in_minute_reg;

    logic                            out_valid_reg;
    wanf_pkg::eval_res_t             out_res_reg;
    logic [ALARM_W-1:0]              out_alarm_reg;
    logic                            out_skip_ok_reg;
    logic                            out_ring_reg;
    logic [ALARM_W-1:0]              out_ringing_reg;

    logic                            advance;
    logic                            cfg_we;
    logic [wanf_pkg::MINUTE_W-1:0]   wm_reduced;
    logic [wanf_pkg::MINUTE_W-1:0]   cwm_next;
    logic [wanf_pkg::DAY_W-1:0]      skip_next [ALARM_COUNT];
    logic [ALARM_W-1:0]              best_alarm;
    wanf_pkg::eval_res_t             res;
    logic [wanf_pkg::MINUTE_W-1:0]   window_minutes;
    logic                            skip_ok;
    logic                            ring_set;
    logic                            ring_next;
    logic [ALARM_W-1:0]              ringing_next;
    logic [ALARM_W+1:0]              alarm_ext;
    logic [ALARM_W+1:0]              ringing_ext;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    assign wm_reduced = (in_minute_reg >= wanf_pkg::WEEK_MINUTES) ?
                        (in_minute_reg - wanf_pkg::WEEK_MINUTES) : in_minute_reg;
    assign cwm_next   = (in_opcode_reg == wanf_pkg::OP_TIME) ? wm_reduced : cwm_reg;

    always_comb begin
        for (int a = 0; a < ALARM_COUNT; a++) begin
            skip_next[a] = skip_reg[a];
            if (in_opcode_reg == wanf_pkg::OP_SKIP && nearest_valid_reg &&
                nearest_alarm_reg == ALARM_W'(a)) begin
                skip_next[a] = nearest_day_reg + 3'd1;
            end
        end
    end

    wanf_eval #(
        .ALARM_COUNT(ALARM_COUNT)
    ) u_eval (
        .alarms      (alarm_reg),
        .skip_days   (skip_next),
        .week_minute (cwm_next),
        .best_alarm  (best_alarm),
        .res         (res)
    );

    assign window_minutes = wanf_pkg::MINUTE_W'(window_reg)
                          * wanf_pkg::MINUTE_W'(wanf_pkg::MINUTES_PER_HOUR);
    assign ring_set = res.found && (res.minutes_until <= wanf_pkg::RING_LEAD) &&
                      !ring_latch_reg;
    assign skip_ok  = res.found && (res.minutes_until > wanf_pkg::RING_LEAD) &&
                      (skip_next[best_alarm] == '0) &&
                      (res.minutes_until <= window_minutes);
    assign ring_next    = ring_latch_reg || ring_set;
    assign ringing_next = ring_set ? best_alarm : ringing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < ALARM_COUNT; a++) begin
                alarm_reg[a] <= '0;
                skip_reg[a]  <= '0;
            end
            window_reg        <= wanf_pkg::SKIP_WINDOW_RESET;
            cwm_reg           <= '0;
            nearest_valid_reg <= 1'b0;
            nearest_alarm_reg <= '0;
            nearest_day_reg   <= '0;
            ring_latch_reg    <= 1'b0;
            ringing_reg       <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                for (int a = 0; a < ALARM_COUNT; a++) begin
                    if (cfg_index <= wanf_pkg::CFG_ALARM_LAST &&
                        cfg_index == wanf_pkg::CFG_INDEX_W'(a)) begin
                        alarm_reg[a] <= wanf_pkg::alarm_t'(cfg_data);
                        skip_reg[a]  <= '0;
                    end
                end
                if (cfg_index == wanf_pkg::CFG_SKIP_WINDOW) begin
                    window_reg <= cfg_data[wanf_pkg::WINDOW_W-1:0];
                end
            end else if (advance) begin
                for (int a = 0; a < ALARM_COUNT; a++) begin
                    skip_reg[a] <= skip_next[a];
                end
            end
            if (advance) begin
                cwm_reg           <= cwm_next;
                nearest_valid_reg <= res.found;
                nearest_alarm_reg <= best_alarm;
                nearest_day_reg   <= res.day;
                ring_latch_reg    <= ring_next;
                ringing_reg       <= ringing_next;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_minute_reg <= s_week_minute;
        end
        if (advance) begin
            out_res_reg     <= res;
            out_alarm_reg   <= best_alarm;
            out_skip_ok_reg <= skip_ok;
            out_ring_reg    <= ring_next;
            out_ringing_reg <= ringing_next;
        end
    end

    assign alarm_ext   = {2'b00, out_alarm_reg};
    assign ringing_ext = {2'b00, out_ringing_reg};

    assign m_valid         = out_valid_reg;
    assign m_found         = out_res_reg.found;
    assign m_next_alarm    = alarm_ext[wanf_pkg::OUT_ALARM_W-1:0];
    assign m_next_weekday  = out_res_reg.day;
    assign m_next_hour     = out_res_reg.hour;
    assign m_next_minute   = out_res_reg.minute;
    assign m_minutes_until = out_res_reg.minutes_until;
    assign m_skip_possible = out_skip_ok_reg;
    assign m_alarm_active  = out_ring_reg;
    assign m_active_alarm  = ringing_ext[wanf_pkg::OUT_ALARM_W-1:0];

`ifndef SYNTHESIS
    a_until_in_week: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.found |->
        out_res_reg.minutes_until < wanf_pkg::WEEK_MINUTES)
        else $error("minutes until alarm beyond one week");

    a_latch_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_latch_reg |=> ring_latch_reg && $stable(ringing_reg))
        else $error("ring latch changed after being set");

    a_skip_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_skip_ok_reg |->
        out_res_reg.found && out_res_reg.minutes_until > wanf_pkg::RING_LEAD)
        else $error("skip offered without a distant alarm");

    a_nearest_day: assert property (@(posedge aclk) disable iff (!aresetn)
        nearest_valid_reg |-> nearest_day_reg < 3'(wanf_pkg::DAYS_PER_WEEK))
        else $error("nearest weekday out of range");
`endif

endmodule
